// ===== hw/rtl/hpvd_pkg.sv =====
// ----------------------------------------------------------------------------
// hpvd_pkg
// Shared types and constants for the hysteresis peak/valley detector.
// ----------------------------------------------------------------------------
package hpvd_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int POS_BITS    = 32;
	localparam int DELTA_BITS  = 20;
	localparam int FRAC_BITS   = 4;

	// compare width: scaled sample or delta, plus one carry bit
	localparam int SCALED_BITS = SAMPLE_BITS + FRAC_BITS;
	localparam int CMP_BITS    = ((SCALED_BITS > DELTA_BITS) ? SCALED_BITS : DELTA_BITS) + 1;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DELTA      = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_USE_LABELS = 1'd1;

	// extremum kind codes
	localparam logic KIND_MAX = 1'b0;
	localparam logic KIND_MIN = 1'b1;

	// result queue; depth must be a power of two (pointers wrap naturally)
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	// one front request writes up to this many results
	localparam int MAX_RESULTS = 2;
	localparam int NRES_BITS   = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic                   kind;
		logic [POS_BITS-1:0]    position;
		logic [SAMPLE_BITS-1:0] value;
		logic                   last;
	} result_t;

	typedef struct packed {
		logic [NRES_BITS-1:0]         count;
		result_t [MAX_RESULTS-1:0]    rec;
	} qpush_t;

	typedef struct packed {
		logic [FIFO_CNT_BITS-1:0] count;
	} fifo_stat_t;

endpackage

// ===== hw/rtl/hpvd_front.sv =====
// ----------------------------------------------------------------------------
// hpvd_front
// Holds the configuration and tracking state, takes one sample per cycle while
// accept is high and classifies it into zero, one or two queue records.
// ----------------------------------------------------------------------------
module hpvd_front import hpvd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [DELTA_BITS-1:0]   cfg_data,
	input  logic                    accept,
	input  logic [SAMPLE_BITS-1:0]  sample,
	input  logic [POS_BITS-1:0]     label,
	input  logic                    end_of_stream,
	output qpush_t                  qpush
);

	logic [DELTA_BITS-1:0]  delta_q;
	logic                   use_labels_q;

	logic [SAMPLE_BITS-1:0] max_value_q, min_value_q;
	logic [POS_BITS-1:0]    max_pos_q, min_pos_q;
	logic                   max_valid_q, min_valid_q;
	logic                   seek_max_q, min_reported_q;
	logic [POS_BITS-1:0]    index_q;

	logic [POS_BITS-1:0]    pos;
	logic                   max_up, min_up;
	logic [SAMPLE_BITS-1:0] mx, mn, mn2;
	logic [POS_BITS-1:0]    mxp, mnp, mnp2;
	logic [CMP_BITS-1:0]    y_sc, mx_sc, mn_sc, d_ext;
	logic                   fall, rise, hit_max, hit_min, hit;
	result_t                delta_rec, end_rec;

	always_comb begin
		pos    = use_labels_q ? label : index_q;

		// running extrema including this sample; empty tracker means "always replace"
		max_up = !max_valid_q || (sample > max_value_q);
		min_up = !min_valid_q ||
			(min_reported_q ? (sample < min_value_q) : (sample <= min_value_q));
		mx     = max_up ? sample : max_value_q;
		mxp    = max_up ? pos : max_pos_q;
		mn     = min_up ? sample : min_value_q;
		mnp    = min_up ? pos : min_pos_q;

		y_sc   = CMP_BITS'({sample, {FRAC_BITS{1'b0}}});
		mx_sc  = CMP_BITS'({mx, {FRAC_BITS{1'b0}}});
		mn_sc  = CMP_BITS'({mn, {FRAC_BITS{1'b0}}});
		d_ext  = CMP_BITS'(delta_q);
		fall   = (y_sc + d_ext) < mx_sc;
		rise   = y_sc > (mn_sc + d_ext);

		hit_max = seek_max_q && fall;
		hit_min = !seek_max_q && rise;
		hit     = hit_max || hit_min;

		// a reported maximum restarts the minimum at this sample
		mn2    = hit_max ? sample : mn;
		mnp2   = hit_max ? pos : mnp;

		delta_rec.kind     = hit_max ? KIND_MAX : KIND_MIN;
		delta_rec.position = hit_max ? mxp : mnp;
		delta_rec.value    = hit_max ? mx : mn;
		delta_rec.last     = !end_of_stream;

		end_rec.kind       = KIND_MIN;
		end_rec.position   = mnp2;
		end_rec.value      = mn2;
		end_rec.last       = 1'b1;

		qpush.count  = accept ? (NRES_BITS'(hit) + NRES_BITS'(end_of_stream))
			: NRES_BITS'(0);
		qpush.rec[0] = hit ? delta_rec : end_rec;
		qpush.rec[1] = end_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_q      <= '0;
			use_labels_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DELTA:      delta_q      <= cfg_data;
				CFG_USE_LABELS: use_labels_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_valid_q    <= 1'b0;
			min_valid_q    <= 1'b0;
			seek_max_q     <= 1'b0;
			min_reported_q <= 1'b0;
			index_q        <= '0;
		end else if (accept) begin
			if (end_of_stream) begin
				max_valid_q    <= 1'b0;
				min_valid_q    <= 1'b0;
				seek_max_q     <= 1'b0;
				min_reported_q <= 1'b0;
				index_q        <= '0;
			end else begin
				max_valid_q <= 1'b1;
				min_valid_q <= 1'b1;
				if (hit)
					seek_max_q <= !seek_max_q;
				if (hit_min)
					min_reported_q <= 1'b1;
				index_q <= index_q + POS_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (hit_min) begin
				max_value_q <= sample;
				max_pos_q   <= pos;
			end else begin
				max_value_q <= mx;
				max_pos_q   <= mxp;
			end
			min_value_q <= mn2;
			min_pos_q   <= mnp2;
		end
	end

endmodule

// ===== hw/rtl/hpvd_res_fifo.sv =====
// ----------------------------------------------------------------------------
// hpvd_res_fifo
// Result queue between front and output: up to two writes and one read per
// cycle. Raises full when fewer than two slots remain.
// ----------------------------------------------------------------------------
module hpvd_res_fifo import hpvd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  qpush_t     qpush,
	input  logic       pop,
	output result_t    head,
	output logic       empty,
	output logic       full,
	output fifo_stat_t stat
);

	result_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0] count_q;
	logic                     do_pop;

	assign empty      = (count_q == '0);
	assign full       = (count_q > FIFO_CNT_BITS'(FIFO_DEPTH - MAX_RESULTS));
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && !empty;
	assign stat.count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(qpush.count);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(1);
			count_q <= count_q + FIFO_CNT_BITS'(qpush.count) - FIFO_CNT_BITS'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (qpush.count != '0)
			mem_q[wr_ptr_q] <= qpush.rec[0];
		if (qpush.count == NRES_BITS'(MAX_RESULTS))
			mem_q[wr_ptr_q + FIFO_PTR_BITS'(1)] <= qpush.rec[1];
	end

endmodule

// ===== hw/rtl/hysteresis_peak_valley_detector.sv =====
// ----------------------------------------------------------------------------
// hysteresis_peak_valley_detector
// Delta-hysteresis peak/valley detector over a stream of 16-bit samples.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while full is low; a sample's results (none, one
// or two) appear on the result side in the next cycle and leave one
// per pop. The result queue holds four entries and full rises when fewer than
// two are free, so input runs at one sample per cycle as long as results are
// popped at least as fast as they are made; the tracking compare/update loop
// in the front is combinational. Delta is unsigned fixed point with four
// fraction bits; positions are sample indices or labels per use_labels, chosen
// when each extremum is captured. The end_of_stream sample also reports the
// pending minimum and clears the tracker. Write configuration only while idle.
module hysteresis_peak_valley_detector import hpvd_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [DELTA_BITS-1:0]       cfg_data,
	input  logic                        push,
	output logic                        full,
	input  logic [SAMPLE_BITS-1:0]      sample,
	input  logic signed [POS_BITS-1:0]  label,
	input  logic                        end_of_stream,
	output logic                        empty,
	input  logic                        pop,
	output logic                        extremum_kind,
	output logic signed [POS_BITS-1:0]  position,
	output logic [SAMPLE_BITS-1:0]      value,
	output logic                        last_of_run
);

	logic       accept;
	qpush_t     qpush;
	result_t    head;
	fifo_stat_t stat;

	assign accept = push && !full;

	hpvd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.accept        (accept),
		.sample        (sample),
		.label         (label),
		.end_of_stream (end_of_stream),
		.qpush         (qpush)
	);

	hpvd_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.qpush  (qpush),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full),
		.stat   (stat)
	);

	assign extremum_kind = head.kind;
	assign position      = head.position;
	assign value         = head.value;
	assign last_of_run   = head.last;

`ifndef ASSERT_OFF
	// an end-of-stream sample always leaves at least one result queued
	a_eos_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_stream |=> !empty)
		else $error("end of stream produced no result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= FIFO_CNT_BITS'(FIFO_DEPTH))
		else $error("result queue overflow");

	// occupancy moves only on an accepted request or a pop
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept && !(pop && !empty) |=> $stable(stat.count))
		else $error("result queue count changed while idle");

	a_full_room: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> (stat.count + FIFO_CNT_BITS'(MAX_RESULTS)) <= FIFO_CNT_BITS'(FIFO_DEPTH))
		else $error("full low without room for two results");
`endif

endmodule

// ===== tb/sv/hysteresis_peak_valley_detector_tb.sv =====
// ----------------------------------------------------------------------------
// hysteresis_peak_valley_detector_tb
// Self-checking bench for the delta-hysteresis peak/valley detector.
// ----------------------------------------------------------------------------
// A behavioral tracker predicts every reported extremum from the accepted
// samples and the current delta and label setting. Results are popped under a
// changing stall pattern and compared in order. A short directed run covers
// the tie rule, the exact delta boundary, label extremes and the double
// minimum on end of stream. It is followed by random streams under several
// settings, including zero delta and the largest delta.
module hysteresis_peak_valley_detector_tb;
	import hpvd_pkg::*;

	typedef enum int {POP_ALWAYS, POP_COIN, POP_PERIODIC, POP_SPARSE} pop_style_t;

	class extremum_board;
		int unsigned delta;
		bit use_labels;
		int errors;
		result_t pending_extrema[$];

		int peak_val;
		logic [POS_BITS-1:0] peak_pos;
		int valley_val;
		logic [POS_BITS-1:0] valley_pos;
		bit hunting_peak;
		bit valley_seen;
		logic [POS_BITS-1:0] index;

		function new();
			delta = 0;
			use_labels = 0;
			errors = 0;
			restart();
		endfunction

		function void restart();
			peak_val = -1;
			peak_pos = '1;
			valley_val = 1 << SAMPLE_BITS;
			valley_pos = '1;
			hunting_peak = 0;
			valley_seen = 0;
			index = '0;
		endfunction

		function int pending();
			return pending_extrema.size();
		endfunction

		// predicts the extrema reported by one accepted request
		function void take_sample(logic [SAMPLE_BITS-1:0] s, logic [POS_BITS-1:0] lab,
				logic eos);
			int y;
			logic [POS_BITS-1:0] at;
			longint d;
			result_t batch[$];
			result_t r;
			y = int'(s);
			at = use_labels ? lab : index;
			d = longint'(delta);
			if (y > peak_val) begin
				peak_val = y;
				peak_pos = at;
			end
			// later sample wins a tie until the first minimum goes out
			if (valley_seen ? (y < valley_val) : (y <= valley_val)) begin
				valley_val = y;
				valley_pos = at;
			end
			if (hunting_peak) begin
				if (longint'(y) * 16 + d < longint'(peak_val) * 16) begin
					r = '{KIND_MAX, peak_pos, peak_val[SAMPLE_BITS-1:0], 1'b0};
					batch.push_back(r);
					valley_val = y;
					valley_pos = at;
					hunting_peak = 0;
				end
			end else if (longint'(y) * 16 > longint'(valley_val) * 16 + d) begin
				r = '{KIND_MIN, valley_pos, valley_val[SAMPLE_BITS-1:0], 1'b0};
				batch.push_back(r);
				valley_seen = 1;
				peak_val = y;
				peak_pos = at;
				hunting_peak = 1;
			end
			index = index + 1;
			if (eos) begin
				r = '{KIND_MIN, valley_pos, valley_val[SAMPLE_BITS-1:0], 1'b0};
				batch.push_back(r);
				restart();
			end
			if (batch.size() > 0)
				batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i])
				pending_extrema.push_back(batch[i]);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void check_extremum(logic kind, logic [POS_BITS-1:0] pos,
				logic [SAMPLE_BITS-1:0] val, logic last);
			result_t want;
			if (pending_extrema.size() == 0) begin
				flag($sformatf("unexpected result kind=%0d pos=%h value=%0d last=%0d",
					kind, pos, val, last));
				return;
			end
			want = pending_extrema.pop_front();
			if (want.kind !== kind || want.position !== pos || want.value !== val ||
					want.last !== last)
				flag({$sformatf("exp kind=%0d pos=%h value=%0d last=%0d",
					want.kind, want.position, want.value, want.last),
					$sformatf(", got kind=%0d pos=%h value=%0d last=%0d",
					kind, pos, val, last)});
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = CFG_DELTA;
	logic [DELTA_BITS-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic [SAMPLE_BITS-1:0] sample = '0;
	logic signed [POS_BITS-1:0] label = '0;
	logic end_of_stream = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic extremum_kind;
	logic signed [POS_BITS-1:0] position;
	logic [SAMPLE_BITS-1:0] value;
	logic last_of_run;

	extremum_board board = new();
	int burst_left = 0;

	hysteresis_peak_valley_detector uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.sample(sample),
		.label(label),
		.end_of_stream(end_of_stream),
		.empty(empty),
		.pop(pop),
		.extremum_kind(extremum_kind),
		.position(position),
		.value(value),
		.last_of_run(last_of_run)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// called at a rising edge; returns at the accepting edge or after a burst's idle gap
	task automatic offer_sample(logic [SAMPLE_BITS-1:0] s, logic [POS_BITS-1:0] lab,
			logic eos);
		sample <= s;
		label <= lab;
		end_of_stream <= eos;
		push <= 1'b1;
		@(negedge clk);
		while (full)
			@(negedge clk);
		board.take_sample(s, lab, eos);
		@(posedge clk);
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
				: $urandom_range(0, 30);
		end else begin
			burst_left--;
		end
	endtask

	// drain all expected results, then give the front time to go quiet
	task automatic settle();
		push <= 1'b0;
		while (board.pending() > 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DELTA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_DELTA)
			board.delta = 32'(data);
		else
			board.use_labels = data[0];
		@(posedge clk);
	endtask

	task automatic run_streams(int budget);
		int sent;
		int len;
		int stepmax;
		int y;
		int step;
		logic eos;
		sent = 0;
		while (sent < budget) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120)
				: $urandom_range(1, 40);
			stepmax = board.delta / 16 * 2 + 3;
			if (stepmax > 65535)
				stepmax = 65535;
			y = $urandom_range(0, 65535);
			for (int k = 0; k < len; k++) begin
				case ($urandom_range(0, 19))
					0: y = 0;
					1: y = 65535;
					2: y = $urandom_range(0, 65535);
					default: begin
						step = $urandom_range(0, stepmax);
						y = $urandom_range(0, 1) ? y + step : y - step;
					end
				endcase
				if (y < 0)
					y = 0;
				if (y > 65535)
					y = 65535;
				// mostly well-formed streams; some run on, some end early
				eos = (k == len - 1) ? ($urandom_range(0, 9) != 0)
					: ($urandom_range(0, 99) == 0);
				offer_sample(y[SAMPLE_BITS-1:0], $urandom, eos);
				sent++;
			end
		end
	endtask

	initial begin
		pop_style_t style;
		int style_left;
		int period;
		int tick;
		style = POP_ALWAYS;
		style_left = 0;
		period = 2;
		tick = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (style_left == 0) begin
				style = pop_style_t'($urandom_range(0, 3));
				style_left = $urandom_range(16, 200);
				period = $urandom_range(2, 9);
			end
			style_left--;
			tick++;
			case (style)
				POP_ALWAYS: pop <= 1'b1;
				POP_COIN: pop <= ($urandom_range(0, 1) != 0);
				POP_PERIODIC: pop <= (tick % period) != 0;
				default: pop <= ($urandom_range(0, 7) == 0);
			endcase
			@(negedge clk);
			if (pop && !empty)
				board.check_extremum(extremum_kind, position, value, last_of_run);
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: zero delta, sample indices
		offer_sample(16'd100, $urandom, 1'b0);
		offer_sample(16'd100, $urandom, 1'b0);   // tie before first minimum: later wins
		offer_sample(16'd0, $urandom, 1'b0);
		offer_sample(16'd0, $urandom, 1'b0);
		offer_sample(16'hffff, $urandom, 1'b0);  // reports minimum
		offer_sample(16'hffff, $urandom, 1'b0);
		offer_sample(16'hfffe, $urandom, 1'b0);  // reports maximum
		offer_sample(16'hfffe, $urandom, 1'b0);  // tie after first minimum: kept
		offer_sample(16'hffff, $urandom, 1'b0);
		offer_sample(16'd0, $urandom, 1'b1);     // maximum, then pending minimum
		offer_sample(16'd5, $urandom, 1'b0);
		offer_sample(16'd6, $urandom, 1'b1);     // same minimum twice
		offer_sample(16'hffff, $urandom, 1'b1);
		offer_sample(16'd0, $urandom, 1'b1);
		settle();

		write_reg(CFG_DELTA, '1);
		write_reg(CFG_USE_LABELS, DELTA_BITS'(1));
		offer_sample(16'hffff, 32'h7fffffff, 1'b0);
		offer_sample(16'd0, 32'h80000000, 1'b0);
		offer_sample(16'd0, 32'hffffffff, 1'b0);
		offer_sample(16'hffff, 32'h00000000, 1'b1);
		settle();

		// delta of exactly one sample unit: equal rise or fall does not count
		write_reg(CFG_DELTA, 20'd16);
		offer_sample(16'd10, $urandom, 1'b0);
		offer_sample(16'd11, $urandom, 1'b0);
		offer_sample(16'd12, $urandom, 1'b0);
		offer_sample(16'd11, $urandom, 1'b0);
		offer_sample(16'd10, $urandom, 1'b0);
		offer_sample(16'd10, $urandom, 1'b1);
		settle();

		write_reg(CFG_DELTA, '0);
		run_streams(170);
		settle();
		write_reg(CFG_DELTA, '1);
		write_reg(CFG_USE_LABELS, DELTA_BITS'(0));
		run_streams(150);
		settle();
		write_reg(CFG_DELTA, DELTA_BITS'($urandom_range(1, 15)));
		write_reg(CFG_USE_LABELS, DELTA_BITS'(1));
		run_streams(170);
		settle();
		write_reg(CFG_DELTA, DELTA_BITS'(16 * $urandom_range(1, 300)));
		write_reg(CFG_USE_LABELS, DELTA_BITS'(0));
		run_streams(170);
		settle();
		write_reg(CFG_DELTA, DELTA_BITS'($urandom_range(0, 1048575)));
		write_reg(CFG_USE_LABELS, DELTA_BITS'(1));
		run_streams(170);
		settle();
		write_reg(CFG_DELTA, DELTA_BITS'($urandom_range(16, 4000)));
		run_streams(170);

		push <= 1'b0;
		while (board.pending() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("PASS hysteresis_peak_valley_detector");
		else
			$display("FAIL hysteresis_peak_valley_detector");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("FAIL hysteresis_peak_valley_detector");
		$finish;
	end

endmodule
